/* rtl/crt_three_moduli_defines.svh */
// Assertion helpers for the CRT solver
`ifndef CRT_THREE_MODULI_DEFINES_SVH
`define CRT_THREE_MODULI_DEFINES_SVH

// same-cycle implication, masked during reset
`define CRT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, masked during reset
`define CRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked through reset
`define CRT_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/crt_pkg.sv */
`default_nettype none
package crt_pkg;
   localparam int SOLUTION_WIDTH = 48;

   typedef struct packed {
      logic done;
      logic bad;
   } lane_stat_type;
endpackage
`default_nettype wire

/* rtl/crt_if.sv */
`default_nettype none
interface crt_req_if #(
   parameter int NUM_CONGRUENCES = 3,
   parameter int MODULUS_WIDTH   = 16
);
   logic                                     valid;
   logic                                     ready;
   logic [NUM_CONGRUENCES*MODULUS_WIDTH-1:0] residue;
   logic [NUM_CONGRUENCES*MODULUS_WIDTH-1:0] modulus;

   modport source (output valid, output residue, output modulus, input ready);
   modport sink (input valid, input residue, input modulus, output ready);
endinterface

interface crt_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [crt_pkg::SOLUTION_WIDTH-1:0] solution;
   logic                              not_coprime;

   modport source (output valid, output solution, output not_coprime, input ready);
   modport sink (input valid, input solution, input not_coprime, output ready);
endinterface
`default_nettype wire

/* rtl/crt_lane.sv */
`default_nettype none
module crt_lane #(
   parameter int NUM_CONGRUENCES = 3,
   parameter int MODULUS_WIDTH   = 16,
   parameter int LANE            = 0
) (
   input  wire                                           clock,
   input  wire                                           reset,
   input  wire                                           start,
   input  wire  [NUM_CONGRUENCES*MODULUS_WIDTH-1:0]      moduli,
   input  wire  [MODULUS_WIDTH-1:0]                      residue,
   output logic [NUM_CONGRUENCES*MODULUS_WIDTH-1:0]      cofactor,
   output logic [NUM_CONGRUENCES*MODULUS_WIDTH-1:0]      term,
   output crt_pkg::lane_stat_type                        stat
);
   localparam int N  = NUM_CONGRUENCES;
   localparam int W  = MODULUS_WIDTH;
   localparam int PW = N * W;
   localparam int DW = (PW > 2 * W) ? PW : 2 * W;
   localparam int CW = $clog2(DW + 1);
   localparam int JW = $clog2(N + 1);
   localparam int SW = W + 2;

   typedef enum logic [3:0] {
      S_IDLE, S_CSEL, S_MUL, S_RED, S_ECHK, S_EDIV, S_UPD,
      S_INV, S_TMUL, S_TRED, S_TERM, S_DONE
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [JW-1:0]   j_ff, j_in;
   logic [PW-1:0]   mcand_ff, mcand_in, prod_ff, prod_in, cof_ff, cof_in, term_ff, term_in;
   logic [W-1:0]    mplier_ff, mplier_in;
   logic [DW-1:0]   dvd_ff, dvd_in;
   logic [W-1:0]    rem_ff, rem_in, quo_ff, quo_in, dsr_ff, dsr_in;
   logic [W-1:0]    r0_ff, r0_in, r1_ff, r1_in, inv_ff, inv_in;
   logic signed [SW-1:0] s0_ff, s0_in, s1_ff, s1_in;
   logic            bad_ff, bad_in;

   logic [W-1:0]    own_mod, mod_sel, rem_next, quo_next;
   logic [PW-1:0]   prod_add;
   logic [W:0]      trial;
   logic            ge;
   logic signed [2*W+2:0] qs;
   logic signed [SW-1:0]  s_upd, s_fix;
   logic [2*W-1:0]  rp;

   assign own_mod = moduli[LANE*W +: W];

   always_comb begin
      mod_sel = '0;
      for (int k = 0; k < N; k++) begin
         if (j_ff == JW'(k)) mod_sel = moduli[k*W +: W];
      end
   end

   assign prod_add = mplier_ff[0] ? prod_ff + mcand_ff : prod_ff;
   assign trial    = {rem_ff, dvd_ff[DW-1]};
   assign ge       = trial >= {1'b0, dsr_ff};
   assign rem_next = ge ? W'(trial - {1'b0, dsr_ff}) : trial[W-1:0];
   assign quo_next = {quo_ff[W-2:0], ge};
   assign qs       = $signed({1'b0, quo_ff}) * s1_ff;
   assign s_upd    = s0_ff - $signed(qs[SW-1:0]);
   assign s_fix    = s0_ff[SW-1] ? s0_ff + $signed({2'b00, own_mod}) : s0_ff;
   assign rp       = residue * inv_ff;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      j_in      = j_ff;
      mcand_in  = mcand_ff;
      prod_in   = prod_ff;
      cof_in    = cof_ff;
      term_in   = term_ff;
      mplier_in = mplier_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dsr_in    = dsr_ff;
      r0_in     = r0_ff;
      r1_in     = r1_ff;
      inv_in    = inv_ff;
      s0_in     = s0_ff;
      s1_in     = s1_ff;
      bad_in    = bad_ff;
      case (state_ff)
         S_IDLE, S_DONE: begin
            if (start) begin
               cof_in   = PW'(1);
               j_in     = '0;
               bad_in   = 1'b0;
               state_in = S_CSEL;
            end
         end
         S_CSEL: begin
            if (j_ff == JW'(N)) begin
               dvd_in   = DW'(cof_ff) << (DW - PW);
               cnt_in   = CW'(PW);
               rem_in   = '0;
               quo_in   = '0;
               dsr_in   = own_mod;
               state_in = S_RED;
            end else if (j_ff == JW'(LANE)) begin
               j_in = j_ff + 1'b1;
            end else begin
               prod_in   = '0;
               mcand_in  = cof_ff;
               mplier_in = mod_sel;
               cnt_in    = CW'(W);
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            prod_in   = prod_add;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               cof_in   = prod_add;
               j_in     = j_ff + 1'b1;
               state_in = S_CSEL;
            end
         end
         S_RED: begin
            dvd_in = dvd_ff << 1;
            rem_in = rem_next;
            quo_in = quo_next;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               r0_in    = rem_next;
               r1_in    = own_mod;
               s0_in    = SW'(1);
               s1_in    = '0;
               state_in = S_ECHK;
            end
         end
         S_ECHK: begin
            if (r1_ff == '0) begin
               state_in = S_INV;
            end else begin
               dvd_in   = DW'(r0_ff) << (DW - W);
               cnt_in   = CW'(W);
               rem_in   = '0;
               quo_in   = '0;
               dsr_in   = r1_ff;
               state_in = S_EDIV;
            end
         end
         S_EDIV: begin
            dvd_in = dvd_ff << 1;
            rem_in = rem_next;
            quo_in = quo_next;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               r0_in    = r1_ff;
               r1_in    = rem_next;
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            s0_in    = s1_ff;
            s1_in    = s_upd;
            state_in = S_ECHK;
         end
         S_INV: begin
            bad_in   = r0_ff > W'(1);
            inv_in   = (r0_ff > W'(1)) ? '0 : s_fix[W-1:0];
            state_in = S_TMUL;
         end
         S_TMUL: begin
            dvd_in   = DW'(rp) << (DW - 2 * W);
            cnt_in   = CW'(2 * W);
            rem_in   = '0;
            quo_in   = '0;
            dsr_in   = own_mod;
            state_in = S_TRED;
         end
         S_TRED: begin
            dvd_in = dvd_ff << 1;
            rem_in = rem_next;
            quo_in = quo_next;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               mplier_in = rem_next;
               mcand_in  = cof_ff;
               prod_in   = '0;
               cnt_in    = CW'(W);
               state_in  = S_TERM;
            end
         end
         S_TERM: begin
            prod_in   = prod_add;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               term_in  = prod_add;
               state_in = S_DONE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff    <= cnt_in;
      j_ff      <= j_in;
      mcand_ff  <= mcand_in;
      prod_ff   <= prod_in;
      cof_ff    <= cof_in;
      term_ff   <= term_in;
      mplier_ff <= mplier_in;
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dsr_ff    <= dsr_in;
      r0_ff     <= r0_in;
      r1_ff     <= r1_in;
      inv_ff    <= inv_in;
      s0_ff     <= s0_in;
      s1_ff     <= s1_in;
      bad_ff    <= bad_in;
   end

   assign cofactor  = cof_ff;
   assign term      = term_ff;
   assign stat.done = (state_ff == S_DONE);
   assign stat.bad  = bad_ff;
endmodule
`default_nettype wire

/* rtl/crt_merge.sv */
`default_nettype none
module crt_merge #(
   parameter int NUM_CONGRUENCES = 3,
   parameter int MODULUS_WIDTH   = 16
) (
   input  wire                                                   clock,
   input  wire                                                   reset,
   input  wire                                                   start,
   input  wire                                                   ack,
   input  wire  [NUM_CONGRUENCES*MODULUS_WIDTH-1:0]              cof0,
   input  wire  [MODULUS_WIDTH-1:0]                              mod0,
   input  wire  [NUM_CONGRUENCES*NUM_CONGRUENCES*MODULUS_WIDTH-1:0] terms,
   input  wire  [NUM_CONGRUENCES-1:0]                            bads,
   output logic                                                  done,
   output logic [crt_pkg::SOLUTION_WIDTH-1:0]                    solution,
   output logic                                                  not_coprime
);
   localparam int N  = NUM_CONGRUENCES;
   localparam int W  = MODULUS_WIDTH;
   localparam int PW = N * W;
   localparam int CW = $clog2(W + 1);
   localparam int KW = $clog2(N + 1);
   localparam int SOLW = crt_pkg::SOLUTION_WIDTH;
   localparam int XW = (PW > SOLW) ? PW : SOLW;

   typedef enum logic [1:0] {M_IDLE, M_MUL, M_ACC, M_DONE} state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [KW-1:0] k_ff, k_in;
   logic [PW-1:0] mcand_ff, mcand_in, prod_ff, prod_in, pm_ff, pm_in, acc_ff, acc_in;
   logic [W-1:0]  mplier_ff, mplier_in;
   logic [SOLW-1:0] sol_ff, sol_in;
   logic          nc_ff, nc_in;

   logic [PW-1:0] prod_add, term_sel, room, final_acc;
   logic [XW-1:0] sol_ext;

   assign prod_add  = mplier_ff[0] ? prod_ff + mcand_ff : prod_ff;
   assign room      = pm_ff - acc_ff;
   assign final_acc = (acc_ff == '0) ? pm_ff : acc_ff;
   assign sol_ext   = XW'(final_acc);

   always_comb begin
      term_sel = '0;
      for (int k = 0; k < N; k++) begin
         if (k_ff == KW'(k)) term_sel = terms[k*PW +: PW];
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      k_in      = k_ff;
      mcand_in  = mcand_ff;
      prod_in   = prod_ff;
      pm_in     = pm_ff;
      acc_in    = acc_ff;
      mplier_in = mplier_ff;
      sol_in    = sol_ff;
      nc_in     = nc_ff;
      case (state_ff)
         M_IDLE: begin
            if (start) begin
               mcand_in  = cof0;
               mplier_in = mod0;
               prod_in   = '0;
               cnt_in    = CW'(W);
               state_in  = M_MUL;
            end
         end
         M_MUL: begin
            prod_in   = prod_add;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               pm_in    = prod_add;
               acc_in   = '0;
               k_in     = '0;
               state_in = M_ACC;
            end
         end
         M_ACC: begin
            if (k_ff == KW'(N)) begin
               if (pm_ff == '0) begin
                  sol_in = '0;
                  nc_in  = 1'b0;
               end else begin
                  sol_in = sol_ext[SOLW-1:0];
                  nc_in  = |bads;
               end
               state_in = M_DONE;
            end else begin
               acc_in = (term_sel >= room) ? term_sel - room : acc_ff + term_sel;
               k_in   = k_ff + 1'b1;
            end
         end
         M_DONE: begin
            if (ack) state_in = M_IDLE;
         end
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff    <= cnt_in;
      k_ff      <= k_in;
      mcand_ff  <= mcand_in;
      prod_ff   <= prod_in;
      pm_ff     <= pm_in;
      acc_ff    <= acc_in;
      mplier_ff <= mplier_in;
      sol_ff    <= sol_in;
      nc_ff     <= nc_in;
   end

   assign done        = (state_ff == M_DONE);
   assign solution    = sol_ff;
   assign not_coprime = nc_ff;
endmodule
`default_nettype wire

/* rtl/crt_three_moduli.sv */
// Chinese remainder solver over NUM_CONGRUENCES residue/modulus pairs.
// req_chan: valid/ready transaction carrying residue and modulus, packed
//   NUM_CONGRUENCES fields of MODULUS_WIDTH bits, field i at [i*W +: W].
// rsp_chan: valid/ready transaction carrying the 48-bit solution and the
//   not_coprime flag; a zero modulus gives solution 0 and not_coprime 0.
// One transaction is computed at a time; req_chan.ready is high only idle.
// Each lane builds its cofactor with shift-add multiplies, reduces it, runs
//   extended Euclid on a bit-serial divider, then forms its term; the merge
//   stage multiplies out M and sums the terms modulo M.
// Transaction time is data dependent through E, the largest Euclid step
//   count over the lanes (E <= ~25 at W = MODULUS_WIDTH = 16).
// A finished result waits in the output register while rsp_chan.ready is
//   low; one more request is taken and computed meanwhile, and it holds in
//   the merge stage, blocking further requests, until the register frees.
// Synchronous reset returns the block to idle with no response pending.
`default_nettype none
module crt_three_moduli #(
   parameter int NUM_CONGRUENCES = 3,
   parameter int MODULUS_WIDTH   = 16
) (
   input wire        clock,
   input wire        reset,
   crt_req_if.sink   req_chan,
   crt_rsp_if.source rsp_chan
);
   localparam int N  = NUM_CONGRUENCES;
   localparam int W  = MODULUS_WIDTH;
   localparam int PW = N * W;

   typedef enum logic [2:0] {T_IDLE, T_START, T_LANE, T_MSTART, T_MERGE} state_type;

   state_type    state_ff, state_in;
   logic [PW-1:0] res_ff, res_in, mod_ff, mod_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [crt_pkg::SOLUTION_WIDTH-1:0] sol_ff, sol_in;
   logic         nc_ff, nc_in;

   crt_pkg::lane_stat_type lane_stat [N];
   logic [N-1:0]    lane_done, lane_bad;
   logic [N*PW-1:0] terms;
   logic [PW-1:0]   cofs [N];
   logic            merge_done, merge_nc, load;
   logic [crt_pkg::SOLUTION_WIDTH-1:0] merge_sol;

   for (genvar g = 0; g < N; g++) begin : g_lane
      crt_lane #(
         .NUM_CONGRUENCES(N),
         .MODULUS_WIDTH  (W),
         .LANE           (g)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .start   (state_ff == T_START),
         .moduli  (mod_ff),
         .residue (res_ff[g*W +: W]),
         .cofactor(cofs[g]),
         .term    (terms[g*PW +: PW]),
         .stat    (lane_stat[g])
      );
      assign lane_done[g] = lane_stat[g].done;
      assign lane_bad[g]  = lane_stat[g].bad;
   end

   crt_merge #(
      .NUM_CONGRUENCES(N),
      .MODULUS_WIDTH  (W)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .start      (state_ff == T_MSTART),
      .ack        (load),
      .cof0       (cofs[0]),
      .mod0       (mod_ff[W-1:0]),
      .terms      (terms),
      .bads       (lane_bad),
      .done       (merge_done),
      .solution   (merge_sol),
      .not_coprime(merge_nc)
   );

   assign load = (state_ff == T_MERGE) && merge_done && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in     = state_ff;
      res_in       = res_ff;
      mod_in       = mod_ff;
      sol_in       = sol_ff;
      nc_in        = nc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      case (state_ff)
         T_IDLE: begin
            if (req_chan.valid) begin
               res_in   = req_chan.residue;
               mod_in   = req_chan.modulus;
               state_in = T_START;
            end
         end
         T_START:  state_in = T_LANE;
         T_LANE:   if (&lane_done) state_in = T_MSTART;
         T_MSTART: state_in = T_MERGE;
         T_MERGE: begin
            if (load) begin
               sol_in       = merge_sol;
               nc_in        = merge_nc;
               rsp_valid_in = 1'b1;
               state_in     = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_ff <= res_in;
      mod_ff <= mod_in;
      sol_ff <= sol_in;
      nc_ff  <= nc_in;
   end

   assign req_chan.ready       = (state_ff == T_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.solution    = sol_ff;
   assign rsp_chan.not_coprime = nc_ff;
endmodule
`default_nettype wire

/* rtl/crt_three_moduli_checker.sv */
`default_nettype none
`include "crt_three_moduli_defines.svh"
module crt_three_moduli_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               req_valid,
   input wire                               req_ready,
   input wire                               rsp_valid,
   input wire                               rsp_ready,
   input wire [crt_pkg::SOLUTION_WIDTH-1:0] rsp_solution,
   input wire                               rsp_not_coprime
);
   `CRT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_solution))
   `CRT_ASSERT_NOW(a_zero_clean, clock, reset, rsp_valid && rsp_solution == '0, !rsp_not_coprime)
   `CRT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `CRT_ASSERT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)
endmodule

bind crt_three_moduli crt_three_moduli_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_solution   (rsp_chan.solution),
   .rsp_not_coprime(rsp_chan.not_coprime)
);
`default_nettype wire
